// ----- rtl/core/slbw_pkg.sv -----
`timescale 1ns / 1ps
package slbw_pkg;

  localparam int PixelBits   = 24;
  localparam int DurBits     = 15;
  localparam int IdxBits     = $clog2(PixelBits + 1);
  localparam int QDepth      = 4;
  localparam int QPtrBits    = $clog2(QDepth);
  localparam int QCntBits    = $clog2(QDepth + 1);
  localparam int ApbAddrBits = 5;
  localparam int ApbDataBits = 32;

  typedef enum logic [2:0] {
    OpTick     = 3'd0,
    OpSetNamed = 3'd1,
    OpSetRaw   = 3'd2,
    OpCycle    = 3'd3,
    OpLinkLost = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ColRed   = 2'd0,
    ColGreen = 2'd1,
    ColBlue  = 2'd2,
    ColOff   = 2'd3
  } colour_e;

  typedef enum logic [2:0] {
    RegBrightness = 3'd0,
    RegInterval   = 3'd1,
    RegZeroHigh   = 3'd2,
    RegZeroLow    = 3'd3,
    RegOneHigh    = 3'd4,
    RegOneLow     = 3'd5,
    RegLatch      = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    colour_e colour;
    logic    raw_mode;
    logic    link_lost;
  } status_t;

  typedef struct packed {
    logic [PixelBits-1:0] word;
    status_t              status;
  } frame_t;

  typedef struct packed {
    logic [7:0]  brightness;
    logic [15:0] blink_interval;
  } front_cfg_t;

  typedef struct packed {
    logic [DurBits-1:0] zero_high;
    logic [DurBits-1:0] zero_low;
    logic [DurBits-1:0] one_high;
    logic [DurBits-1:0] one_low;
    logic [DurBits-1:0] latch;
  } sym_cfg_t;

  typedef struct packed {
    logic               first_level;
    logic [DurBits-1:0] first_ticks;
    logic               second_level;
    logic [DurBits-1:0] second_ticks;
    logic               frame_end;
    logic [1:0]         current_colour;
    logic               raw_mode;
    logic               link_lost;
  } sym_t;

endpackage

// ----- rtl/core/slbw_if.sv -----
`timescale 1ns / 1ps
interface slbw_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [31:0] now_ms;
  logic [1:0] colour_sel;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       lost_flag;

  modport source (output valid, opcode, now_ms, colour_sel, red_in, green_in, blue_in,
                  lost_flag, input ready);
  modport sink (input valid, opcode, now_ms, colour_sel, red_in, green_in, blue_in,
                lost_flag, output ready);
endinterface

interface slbw_sym_if;
  logic                        valid;
  logic                        ready;
  logic                        first_level;
  logic [slbw_pkg::DurBits-1:0] first_ticks;
  logic                        second_level;
  logic [slbw_pkg::DurBits-1:0] second_ticks;
  logic                        frame_end;
  logic [1:0]                  current_colour;
  logic                        raw_mode;
  logic                        link_lost;

  modport source (output valid, first_level, first_ticks, second_level, second_ticks,
                  frame_end, current_colour, raw_mode, link_lost, input ready);
  modport sink (input valid, first_level, first_ticks, second_level, second_ticks,
                frame_end, current_colour, raw_mode, link_lost, output ready);
endinterface

// ----- rtl/core/slbw_front.sv -----
`timescale 1ns / 1ps
module slbw_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  slbw_cmd_if.sink             cmd,
  input  slbw_pkg::front_cfg_t cfg_i,
  output logic                 push_o,
  output slbw_pkg::frame_t     push_data_o,
  input  logic                 push_ready_i
);

  function automatic slbw_pkg::rgb_t named_rgb(input slbw_pkg::colour_e c, input logic on);
    slbw_pkg::rgb_t v;
    v = '0;
    if (on) begin
      case (c)
        slbw_pkg::ColRed:   v.r = 8'hFF;
        slbw_pkg::ColGreen: v.g = 8'hFF;
        slbw_pkg::ColBlue:  v.b = 8'hFF;
        default:            v   = '0;
      endcase
    end
    return v;
  endfunction

  // exact floor(p / 255) for p up to 255 * 255, the largest 8-bit by 8-bit product
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  slbw_pkg::colour_e colour_q, colour_d;
  logic              lamp_q, lamp_d;
  logic              raw_q, raw_d;
  slbw_pkg::rgb_t    raw_rgb_q, raw_rgb_d;
  logic              lost_q, lost_d;
  logic              red_q, red_d;
  logic [31:0]       last_q, last_d;

  logic              emit;
  slbw_pkg::rgb_t    rgb;
  logic [31:0]       elapsed;
  logic              accept;

  logic              s1_valid_q;
  slbw_pkg::rgb_t    s1_rgb_q;
  slbw_pkg::status_t s1_stat_q;
  logic              s2_valid_q;
  logic [15:0]       s2_prod_q [3];
  slbw_pkg::status_t s2_stat_q;
  logic              s1_adv, s2_adv;

  assign s2_adv    = !s2_valid_q || push_ready_i;
  assign s1_adv    = !s1_valid_q || s2_adv;
  assign cmd.ready = s1_adv;
  assign accept    = cmd.valid && cmd.ready;
  assign elapsed   = cmd.now_ms - last_q;

  always_comb begin
    colour_d  = colour_q;
    lamp_d    = lamp_q;
    raw_d     = raw_q;
    raw_rgb_d = raw_rgb_q;
    lost_d    = lost_q;
    red_d     = red_q;
    last_d    = last_q;
    emit      = 1'b0;
    rgb       = '0;
    case (slbw_pkg::op_e'(cmd.opcode))
      slbw_pkg::OpTick: begin
        if (elapsed >= {16'b0, cfg_i.blink_interval}) begin
          last_d = cmd.now_ms;
          if (lost_q) begin
            red_d = !red_q;
            rgb   = red_d ? named_rgb(slbw_pkg::ColRed, 1'b1)
                          : named_rgb(slbw_pkg::ColBlue, 1'b1);
            emit  = 1'b1;
          end else if (raw_q) begin
            lamp_d = !lamp_q;
            rgb    = lamp_d ? raw_rgb_q : '0;
            emit   = 1'b1;
          end else if (colour_q != slbw_pkg::ColOff) begin
            lamp_d = !lamp_q;
            rgb    = named_rgb(colour_q, lamp_d);
            emit   = 1'b1;
          end
        end
      end
      slbw_pkg::OpSetNamed: begin
        colour_d = slbw_pkg::colour_e'(cmd.colour_sel);
        raw_d    = 1'b0;
        lost_d   = 1'b0;
        lamp_d   = (colour_d != slbw_pkg::ColOff);
        rgb      = named_rgb(colour_d, lamp_d);
        emit     = 1'b1;
      end
      slbw_pkg::OpSetRaw: begin
        raw_rgb_d = '{r: cmd.red_in, g: cmd.green_in, b: cmd.blue_in};
        raw_d     = 1'b1;
        lamp_d    = 1'b1;
        lost_d    = 1'b0;
        rgb       = raw_rgb_d;
        emit      = 1'b1;
      end
      slbw_pkg::OpCycle: begin
        raw_d    = 1'b0;
        colour_d = slbw_pkg::colour_e'(2'(colour_q + 2'd1));
        lamp_d   = (colour_d != slbw_pkg::ColOff);
        rgb      = named_rgb(colour_d, lamp_d);
        emit     = 1'b1;
      end
      slbw_pkg::OpLinkLost: begin
        lost_d = cmd.lost_flag;
        if (!cmd.lost_flag) begin
          rgb  = named_rgb(colour_q, lamp_q);
          emit = 1'b1;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q  <= slbw_pkg::ColRed;
      lamp_q    <= 1'b1;
      raw_q     <= 1'b0;
      raw_rgb_q <= '{r: 8'hFF, g: 8'h00, b: 8'h00};
      lost_q    <= 1'b0;
      red_q     <= 1'b1;
      last_q    <= '0;
    end else if (accept) begin
      colour_q  <= colour_d;
      lamp_q    <= lamp_d;
      raw_q     <= raw_d;
      raw_rgb_q <= raw_rgb_d;
      lost_q    <= lost_d;
      red_q     <= red_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= accept && emit;
      if (s2_adv) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_rgb_q  <= rgb;
      s1_stat_q <= '{colour: colour_d, raw_mode: raw_d, link_lost: lost_d};
    end
    if (s2_adv) begin
      s2_prod_q[0] <= {8'b0, s1_rgb_q.g} * {8'b0, cfg_i.brightness};
      s2_prod_q[1] <= {8'b0, s1_rgb_q.r} * {8'b0, cfg_i.brightness};
      s2_prod_q[2] <= {8'b0, s1_rgb_q.b} * {8'b0, cfg_i.brightness};
      s2_stat_q    <= s1_stat_q;
    end
  end

  // GRB order on the wire
  assign push_o             = s2_valid_q;
  assign push_data_o.word   = {div255(s2_prod_q[0]), div255(s2_prod_q[1]),
                               div255(s2_prod_q[2])};
  assign push_data_o.status = s2_stat_q;

endmodule

// ----- rtl/core/slbw_fifo.sv -----
`timescale 1ns / 1ps
module slbw_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  slbw_pkg::frame_t push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output slbw_pkg::frame_t pop_data_o,
  input  logic             pop_i
);

  slbw_pkg::frame_t                mem_q [slbw_pkg::QDepth];
  logic [slbw_pkg::QPtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [slbw_pkg::QCntBits-1:0]   count_q;
  logic                            do_push, do_pop;

  assign push_ready_o = (count_q != slbw_pkg::QCntBits'(slbw_pkg::QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= slbw_pkg::QCntBits'(slbw_pkg::QDepth))
    else $error("queue count over depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o)
    else $error("pop from empty queue");

endmodule

// ----- rtl/core/slbw_back.sv -----
`timescale 1ns / 1ps
module slbw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               frame_valid_i,
  input  slbw_pkg::frame_t   frame_i,
  output logic               pop_o,
  input  slbw_pkg::sym_cfg_t cfg_i,
  slbw_sym_if.source         sym
);

  logic                           active_q, active_d;
  logic [slbw_pkg::PixelBits-1:0] shreg_q, shreg_d;
  logic [slbw_pkg::IdxBits-1:0]   idx_q, idx_d;
  slbw_pkg::status_t              stat_q, stat_d;
  logic                           out_valid_q, out_valid_d;
  slbw_pkg::sym_t                 out_q, out_d;

  logic              adv, have, cur_bit, is_latch;
  slbw_pkg::status_t cur_stat;

  assign adv      = !out_valid_q || sym.ready;
  assign have     = active_q || frame_valid_i;
  assign cur_bit  = active_q ? shreg_q[slbw_pkg::PixelBits-1]
                             : frame_i.word[slbw_pkg::PixelBits-1];
  assign cur_stat = active_q ? stat_q : frame_i.status;
  assign is_latch = active_q && (idx_q == slbw_pkg::IdxBits'(slbw_pkg::PixelBits));

  always_comb begin
    active_d    = active_q;
    shreg_d     = shreg_q;
    idx_d       = idx_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (adv) begin
      out_valid_d          = have;
      out_d.second_level   = 1'b0;
      out_d.current_colour = cur_stat.colour;
      out_d.raw_mode       = cur_stat.raw_mode;
      out_d.link_lost      = cur_stat.link_lost;
      if (is_latch) begin
        out_d.first_level  = 1'b0;
        out_d.first_ticks  = cfg_i.latch;
        out_d.second_ticks = '0;
        out_d.frame_end    = 1'b1;
      end else begin
        out_d.first_level  = 1'b1;
        out_d.first_ticks  = cur_bit ? cfg_i.one_high : cfg_i.zero_high;
        out_d.second_ticks = cur_bit ? cfg_i.one_low : cfg_i.zero_low;
        out_d.frame_end    = 1'b0;
      end
      if (!active_q) begin
        if (frame_valid_i) begin
          pop_o    = 1'b1;
          active_d = 1'b1;
          shreg_d  = frame_i.word << 1;
          idx_d    = slbw_pkg::IdxBits'(1);
          stat_d   = frame_i.status;
        end
      end else if (is_latch) begin
        active_d = 1'b0;
      end else begin
        shreg_d = shreg_q << 1;
        idx_d   = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    stat_q  <= stat_d;
    out_q   <= out_d;
  end

  assign sym.valid          = out_valid_q;
  assign sym.first_level    = out_q.first_level;
  assign sym.first_ticks    = out_q.first_ticks;
  assign sym.second_level   = out_q.second_level;
  assign sym.second_ticks   = out_q.second_ticks;
  assign sym.frame_end      = out_q.frame_end;
  assign sym.current_colour = out_q.current_colour;
  assign sym.raw_mode       = out_q.raw_mode;
  assign sym.link_lost      = out_q.link_lost;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (idx_q != '0 && idx_q <= slbw_pkg::IdxBits'(slbw_pkg::PixelBits)))
    else $error("symbol index out of range");

  a_latch_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && is_latch) |=> (!active_q && out_valid_q && out_q.frame_end))
    else $error("frame did not close on latch");

endmodule

// ----- rtl/core/status_led_blink_ws2812_encoder_top.sv -----
`timescale 1ns / 1ps
// Status LED controller for one WS2812 pixel.
// cmd: command channel (valid/ready). Opcodes tick, set named colour, set raw
//   colour, cycle colour and set link-lost. Commands that do not rewrite the
//   LED update state and produce nothing.
// sym: symbol channel (valid/ready). Each LED write gives 25 transfers: 24
//   data symbols, GRB MSB first, then a latch symbol flagged by frame_end.
// APB port: seven registers at byte offsets 4*i; the user must write them only
//   while idle, the block does not enforce this. Path: the first symbol of a
//   frame passes two front stages, the frame queue and the output register.
// Throughput: one symbol per cycle while sym.ready is high; consecutive frames
//   follow with no gap. Commands are taken one per cycle until the 4-entry
//   frame queue and both front stages fill.
// Stall: a held symbol keeps its payload; the serialiser waits, the queue
//   fills, then cmd.ready drops. Commands without output still need ready.
// Reset: LED red, lamp on, blink and link-lost idle, registers at defaults;
//   no pending symbols. No clearing pass is needed.
module status_led_blink_ws2812_encoder_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  slbw_cmd_if.sink                             cmd,
  slbw_sym_if.source                           sym,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [slbw_pkg::ApbAddrBits-1:0]     paddr,
  input  logic [slbw_pkg::ApbDataBits-1:0]     pwdata,
  output logic [slbw_pkg::ApbDataBits-1:0]     prdata,
  output logic                                 pready
);

  logic [7:0]                   brightness_q;
  logic [15:0]                  interval_q;
  logic [slbw_pkg::DurBits-1:0] zero_high_q, zero_low_q, one_high_q, one_low_q, latch_q;
  logic                         wr_en;
  slbw_pkg::reg_idx_e           reg_idx;

  slbw_pkg::front_cfg_t front_cfg;
  slbw_pkg::sym_cfg_t   sym_cfg;
  logic                 push, push_ready, pop, pop_valid;
  slbw_pkg::frame_t     push_data, pop_data;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = slbw_pkg::reg_idx_e'(paddr[slbw_pkg::ApbAddrBits-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= 8'd50;
      interval_q   <= 16'd500;
      zero_high_q  <= slbw_pkg::DurBits'(4);
      zero_low_q   <= slbw_pkg::DurBits'(8);
      one_high_q   <= slbw_pkg::DurBits'(8);
      one_low_q    <= slbw_pkg::DurBits'(4);
      latch_q      <= slbw_pkg::DurBits'(500);
    end else if (wr_en) begin
      case (reg_idx)
        slbw_pkg::RegBrightness: brightness_q <= pwdata[7:0];
        slbw_pkg::RegInterval:   interval_q   <= pwdata[15:0];
        slbw_pkg::RegZeroHigh:   zero_high_q  <= pwdata[slbw_pkg::DurBits-1:0];
        slbw_pkg::RegZeroLow:    zero_low_q   <= pwdata[slbw_pkg::DurBits-1:0];
        slbw_pkg::RegOneHigh:    one_high_q   <= pwdata[slbw_pkg::DurBits-1:0];
        slbw_pkg::RegOneLow:     one_low_q    <= pwdata[slbw_pkg::DurBits-1:0];
        slbw_pkg::RegLatch:      latch_q      <= pwdata[slbw_pkg::DurBits-1:0];
        default:                 latch_q      <= latch_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      slbw_pkg::RegBrightness: prdata = {24'b0, brightness_q};
      slbw_pkg::RegInterval:   prdata = {16'b0, interval_q};
      slbw_pkg::RegZeroHigh:   prdata = slbw_pkg::ApbDataBits'(zero_high_q);
      slbw_pkg::RegZeroLow:    prdata = slbw_pkg::ApbDataBits'(zero_low_q);
      slbw_pkg::RegOneHigh:    prdata = slbw_pkg::ApbDataBits'(one_high_q);
      slbw_pkg::RegOneLow:     prdata = slbw_pkg::ApbDataBits'(one_low_q);
      slbw_pkg::RegLatch:      prdata = slbw_pkg::ApbDataBits'(latch_q);
      default:                 prdata = '0;
    endcase
  end

  assign front_cfg = '{brightness: brightness_q, blink_interval: interval_q};
  assign sym_cfg   = '{zero_high: zero_high_q, zero_low: zero_low_q,
                       one_high: one_high_q, one_low: one_low_q, latch: latch_q};

  slbw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd          (cmd),
    .cfg_i        (front_cfg),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  slbw_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_i        (pop)
  );

  slbw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (pop_valid),
    .frame_i       (pop_data),
    .pop_o         (pop),
    .cfg_i         (sym_cfg),
    .sym           (sym)
  );

endmodule

// ----- tb/status_led_blink_ws2812_encoder_top_tb.sv -----
`timescale 1ns / 1ps
module status_led_blink_ws2812_encoder_top_tb;

  typedef struct packed {
    logic [2:0]          opcode;
    logic [31:0]         now_ms;
    slbw_pkg::colour_e   colour_sel;
    logic [7:0]          red_in;
    logic [7:0]          green_in;
    logic [7:0]          blue_in;
    logic                lost_flag;
  } led_cmd_t;

  class led_frame_scoreboard;
    logic [7:0]                   brightness;
    logic [15:0]                  interval;
    logic [slbw_pkg::DurBits-1:0] zero_hi;
    logic [slbw_pkg::DurBits-1:0] zero_lo;
    logic [slbw_pkg::DurBits-1:0] one_hi;
    logic [slbw_pkg::DurBits-1:0] one_lo;
    logic [slbw_pkg::DurBits-1:0] latch;
    slbw_pkg::colour_e            colour;
    logic                         lamp_on;
    logic                         raw_active;
    logic                         lost_active;
    logic                         red_phase;
    slbw_pkg::rgb_t               raw_rgb;
    logic [31:0]                  last_toggle;
    slbw_pkg::sym_t               symbols_due[$];
    int                           mismatches;

    function new();
      brightness  = 8'd50;
      interval    = 16'd500;
      zero_hi     = slbw_pkg::DurBits'(4);
      zero_lo     = slbw_pkg::DurBits'(8);
      one_hi      = slbw_pkg::DurBits'(8);
      one_lo      = slbw_pkg::DurBits'(4);
      latch       = slbw_pkg::DurBits'(500);
      colour      = slbw_pkg::ColRed;
      lamp_on     = 1'b1;
      raw_active  = 1'b0;
      lost_active = 1'b0;
      red_phase   = 1'b1;
      raw_rgb     = '{8'hff, 8'h00, 8'h00};
      last_toggle = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(slbw_pkg::reg_idx_e idx, logic [31:0] v);
      case (idx)
        slbw_pkg::RegBrightness: brightness = v[7:0];
        slbw_pkg::RegInterval:   interval   = v[15:0];
        slbw_pkg::RegZeroHigh:   zero_hi    = v[slbw_pkg::DurBits-1:0];
        slbw_pkg::RegZeroLow:    zero_lo    = v[slbw_pkg::DurBits-1:0];
        slbw_pkg::RegOneHigh:    one_hi     = v[slbw_pkg::DurBits-1:0];
        slbw_pkg::RegOneLow:     one_lo     = v[slbw_pkg::DurBits-1:0];
        slbw_pkg::RegLatch:      latch      = v[slbw_pkg::DurBits-1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] scale(logic [7:0] v);
      int unsigned p;
      p = int'(v) * int'(brightness);
      return 8'(p / 255);
    endfunction

    function void push_frame(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [slbw_pkg::PixelBits-1:0] word;
      slbw_pkg::sym_t                 s;
      word = {scale(g), scale(r), scale(b)};
      s.second_level   = 1'b0;
      s.current_colour = colour;
      s.raw_mode       = raw_active;
      s.link_lost      = lost_active;
      for (int i = slbw_pkg::PixelBits - 1; i >= 0; i--) begin
        s.first_level  = 1'b1;
        s.first_ticks  = word[i] ? one_hi : zero_hi;
        s.second_ticks = word[i] ? one_lo : zero_lo;
        s.frame_end    = 1'b0;
        symbols_due.push_back(s);
      end
      s.first_level  = 1'b0;
      s.first_ticks  = latch;
      s.second_ticks = '0;
      s.frame_end    = 1'b1;
      symbols_due.push_back(s);
    endfunction

    function void push_named();
      if (!lamp_on || colour == slbw_pkg::ColOff) begin
        push_frame(8'h00, 8'h00, 8'h00);
      end else begin
        case (colour)
          slbw_pkg::ColRed:   push_frame(8'hff, 8'h00, 8'h00);
          slbw_pkg::ColGreen: push_frame(8'h00, 8'hff, 8'h00);
          default:            push_frame(8'h00, 8'h00, 8'hff);
        endcase
      end
    endfunction

    function void note_cmd(led_cmd_t c);
      case (c.opcode)
        slbw_pkg::OpTick: begin
          if (c.now_ms - last_toggle < 32'(interval)) return;
          last_toggle = c.now_ms;
          if (lost_active) begin
            red_phase = !red_phase;
            if (red_phase) push_frame(8'hff, 8'h00, 8'h00);
            else push_frame(8'h00, 8'h00, 8'hff);
          end else if (raw_active) begin
            lamp_on = !lamp_on;
            if (lamp_on) push_frame(raw_rgb.r, raw_rgb.g, raw_rgb.b);
            else push_frame(8'h00, 8'h00, 8'h00);
          end else if (colour != slbw_pkg::ColOff) begin
            lamp_on = !lamp_on;
            push_named();
          end
        end
        slbw_pkg::OpSetNamed: begin
          colour      = c.colour_sel;
          raw_active  = 1'b0;
          lost_active = 1'b0;
          lamp_on     = (c.colour_sel != slbw_pkg::ColOff);
          push_named();
        end
        slbw_pkg::OpSetRaw: begin
          raw_rgb     = '{c.red_in, c.green_in, c.blue_in};
          raw_active  = 1'b1;
          lamp_on     = 1'b1;
          lost_active = 1'b0;
          push_frame(c.red_in, c.green_in, c.blue_in);
        end
        slbw_pkg::OpCycle: begin
          raw_active = 1'b0;
          colour     = slbw_pkg::colour_e'(2'(colour + 1));
          lamp_on    = (colour != slbw_pkg::ColOff);
          push_named();
        end
        slbw_pkg::OpLinkLost: begin
          lost_active = c.lost_flag;
          if (!c.lost_flag) push_named();
        end
        default: ;
      endcase
    endfunction

    function void check_sym(slbw_pkg::sym_t got);
      slbw_pkg::sym_t want;
      if (symbols_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected symbol: lvl %0d/%0d ticks %0d/%0d end %0d", got.first_level,
                   got.second_level, got.first_ticks, got.second_ticks, got.frame_end);
        return;
      end
      want = symbols_due.pop_front();
      if (got.first_level !== want.first_level || got.first_ticks !== want.first_ticks ||
          got.second_level !== want.second_level || got.second_ticks !== want.second_ticks ||
          got.frame_end !== want.frame_end || got.current_colour !== want.current_colour ||
          got.raw_mode !== want.raw_mode || got.link_lost !== want.link_lost) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"symbol mismatch: exp lvl %0d/%0d ticks %0d/%0d end %0d st %0d/%0d/%0d,",
                    " got lvl %0d/%0d ticks %0d/%0d end %0d st %0d/%0d/%0d"},
                   want.first_level, want.second_level, want.first_ticks, want.second_ticks,
                   want.frame_end, want.current_colour, want.raw_mode, want.link_lost,
                   got.first_level, got.second_level, got.first_ticks, got.second_ticks,
                   got.frame_end, got.current_colour, got.raw_mode, got.link_lost);
      end
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [slbw_pkg::ApbAddrBits-1:0] paddr;
  logic [slbw_pkg::ApbDataBits-1:0] pwdata;
  logic [slbw_pkg::ApbDataBits-1:0] prdata;
  logic                             pready;

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  logic [31:0] time_ms;

  led_frame_scoreboard sb = new();

  slbw_cmd_if cmd_bus ();
  slbw_sym_if sym_bus ();

  status_led_blink_ws2812_encoder_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd     (cmd_bus),
    .sym     (sym_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    sym_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && sym_bus.valid && sym_bus.ready) begin
      sb.check_sym(slbw_pkg::sym_t'{sym_bus.first_level, sym_bus.first_ticks,
                                    sym_bus.second_level, sym_bus.second_ticks,
                                    sym_bus.frame_end, sym_bus.current_colour,
                                    sym_bus.raw_mode, sym_bus.link_lost});
    end
  end

  function automatic led_cmd_t mk(logic [2:0] op, logic [31:0] now, slbw_pkg::colour_e sel,
                                  logic [7:0] r, logic [7:0] g, logic [7:0] b, logic flag);
    led_cmd_t c;
    c = '{op, now, sel, r, g, b, flag};
    return c;
  endfunction

  function automatic led_cmd_t random_cmd();
    led_cmd_t    c;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) c.opcode = slbw_pkg::OpTick;
    else if (pick < 55) c.opcode = slbw_pkg::OpSetNamed;
    else if (pick < 70) c.opcode = slbw_pkg::OpSetRaw;
    else if (pick < 80) c.opcode = slbw_pkg::OpCycle;
    else if (pick < 92) c.opcode = slbw_pkg::OpLinkLost;
    else c.opcode = 3'($urandom_range(int'(slbw_pkg::OpLinkLost) + 1, 7));
    if ($urandom_range(1)) begin
      time_ms  = time_ms + $urandom_range(0, 2 * int'(sb.interval) + 2);
      c.now_ms = time_ms;
    end else begin
      c.now_ms = $urandom();
    end
    c.colour_sel = slbw_pkg::colour_e'($urandom_range(3));
    c.red_in     = 8'($urandom_range(255));
    c.green_in   = 8'($urandom_range(255));
    c.blue_in    = 8'($urandom_range(255));
    c.lost_flag  = 1'($urandom_range(1));
    return c;
  endfunction

  // called and returns at a falling edge; valid stays high for back-to-back transfers
  task automatic send_cmd(input led_cmd_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.opcode     <= c.opcode;
    cmd_bus.now_ms     <= c.now_ms;
    cmd_bus.colour_sel <= c.colour_sel;
    cmd_bus.red_in     <= c.red_in;
    cmd_bus.green_in   <= c.green_in;
    cmd_bus.blue_in    <= c.blue_in;
    cmd_bus.lost_flag  <= c.lost_flag;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    sb.note_cmd(c);
    @(negedge clk_i);
  endtask

  // commands without a frame may still be in the front stages
  task automatic drain_symbols();
    cmd_bus.valid <= 1'b0;
    while (sb.symbols_due.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic apb_write(input slbw_pkg::reg_idx_e idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= slbw_pkg::ApbAddrBits'(4 * int'(idx));
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input int bright, input int ivl, input int zh, input int zl,
                            input int oh, input int ol, input int la);
    apb_write(slbw_pkg::RegBrightness, 32'(bright));
    apb_write(slbw_pkg::RegInterval, 32'(ivl));
    apb_write(slbw_pkg::RegZeroHigh, 32'(zh));
    apb_write(slbw_pkg::RegZeroLow, 32'(zl));
    apb_write(slbw_pkg::RegOneHigh, 32'(oh));
    apb_write(slbw_pkg::RegOneLow, 32'(ol));
    apb_write(slbw_pkg::RegLatch, 32'(la));
  endtask

  initial begin
    logic [31:0] t;
    led_cmd_t    c;
    int          n;
    cmd_bus.valid      = 1'b0;
    cmd_bus.opcode     = '0;
    cmd_bus.now_ms     = '0;
    cmd_bus.colour_sel = '0;
    cmd_bus.red_in     = '0;
    cmd_bus.green_in   = '0;
    cmd_bus.blue_in    = '0;
    cmd_bus.lost_flag  = 1'b0;
    sym_bus.ready      = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    src_idle_pct       = 0;
    sink_stall_pct     = 0;
    time_ms            = '0;
    rst_ni             = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: blink timing, wrap of the ms counter, modes
    send_cmd(mk(slbw_pkg::OpTick, 32'd0, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00, 1'b0));
    send_cmd(mk(slbw_pkg::OpTick, 32'd500, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00, 1'b0));
    send_cmd(mk(slbw_pkg::OpTick, 32'd999, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00, 1'b0));
    send_cmd(mk(slbw_pkg::OpTick, 32'd1000, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00, 1'b0));
    send_cmd(mk(slbw_pkg::OpSetNamed, 32'd0, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00, 1'b0));
    send_cmd(mk(slbw_pkg::OpSetNamed, 32'd0, slbw_pkg::ColGreen, 8'h00, 8'h00, 8'h00,
                1'b0));
    send_cmd(mk(slbw_pkg::OpSetNamed, 32'd0, slbw_pkg::ColBlue, 8'h00, 8'h00, 8'h00, 1'b0));
    send_cmd(mk(slbw_pkg::OpSetNamed, 32'd0, slbw_pkg::ColOff, 8'h00, 8'h00, 8'h00, 1'b0));
    send_cmd(mk(slbw_pkg::OpTick, 32'hffff_ffff, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00,
                1'b0));
    t = 32'h0000_01f3;
    send_cmd(mk(slbw_pkg::OpTick, t, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00, 1'b0));
    repeat (4)
      send_cmd(mk(slbw_pkg::OpCycle, 32'd0, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00, 1'b0));
    send_cmd(mk(slbw_pkg::OpSetNamed, 32'd0, slbw_pkg::ColBlue, 8'h00, 8'h00, 8'h00, 1'b0));
    send_cmd(mk(slbw_pkg::OpSetRaw, 32'd0, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00, 1'b0));
    send_cmd(mk(slbw_pkg::OpSetRaw, 32'd0, slbw_pkg::ColRed, 8'haa, 8'h55, 8'h0f, 1'b0));
    send_cmd(mk(slbw_pkg::OpSetRaw, 32'hffff_ffff, slbw_pkg::ColOff, 8'hff, 8'hff, 8'hff,
                1'b1));
    t = t + 500;
    send_cmd(mk(slbw_pkg::OpTick, t, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00, 1'b0));
    t = t + 500;
    send_cmd(mk(slbw_pkg::OpTick, t, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00, 1'b0));
    send_cmd(mk(slbw_pkg::OpLinkLost, 32'd0, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00, 1'b1));
    t = t + 500;
    send_cmd(mk(slbw_pkg::OpTick, t, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00, 1'b0));
    t = t + 500;
    send_cmd(mk(slbw_pkg::OpTick, t, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00, 1'b0));
    send_cmd(mk(slbw_pkg::OpLinkLost, 32'd0, slbw_pkg::ColRed, 8'h00, 8'h00, 8'h00, 1'b0));
    for (int k = int'(slbw_pkg::OpLinkLost) + 1; k < 8; k++)
      send_cmd(mk(3'(k), t + 32'd1000, slbw_pkg::ColOff, 8'hff, 8'hff, 8'hff, 1'b1));

    for (int ph = 0; ph < 4; ph++) begin
      drain_symbols();
      case (ph)
        0: begin
          set_config(255, 0, 32767, 0, 0, 32767, 32767);
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          set_config(0, 65535, 0, 32767, 32767, 0, 0);
          src_idle_pct   = 49;
          sink_stall_pct = 0;
        end
        2: begin
          set_config($urandom_range(255), $urandom_range(65535), $urandom_range(32767),
                     $urandom_range(32767), $urandom_range(32767), $urandom_range(32767),
                     $urandom_range(32767));
          src_idle_pct   = 0;
          sink_stall_pct = 49;
        end
        default: begin
          set_config($urandom_range(1, 254), $urandom_range(2000), $urandom_range(32767),
                     $urandom_range(32767), $urandom_range(32767), $urandom_range(32767),
                     $urandom_range(32767));
          src_idle_pct   = 17;
          sink_stall_pct = 17;
        end
      endcase
      n = 0;
      while (n < 125) begin
        c = random_cmd();
        send_cmd(c);
        if (c.opcode <= slbw_pkg::OpLinkLost) begin
          n++;
          if (n == 60) drain_symbols();
        end
      end
    end

    drain_symbols();
    if (sb.mismatches == 0 && sb.symbols_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
